/* design/assert_macros.svh */
// Assertion macros shared by the blur block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/gbr_pkg.sv */
// Shared constants and types of the 3x3 RGB Gaussian blur.
package gbr_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W = $clog2(MAX_WIDTH);

    // Configuration register widths and reset values.
    localparam int CFG_WIDTH_W = 12;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_WIDTH_W-1:0] RESET_WIDTH = 12'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = 16'd480;

    // Effective width must hold both the register value and MAX_WIDTH itself.
    localparam int EW_W = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_W) ?
                          $clog2(MAX_WIDTH + 1) : CFG_WIDTH_W;
    // The input row runs one past the last line while the final line drains.
    localparam int ROW_W = CFG_HEIGHT_W + 1;

    // Weighted sum of nine 8-bit samples with total weight 16 peaks at 4080.
    localparam int SUM_W = 12;
    localparam int DIV_SHIFT = 4;

    // Output queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // One line store entry: the pixel two lines up and the one a line up.
    typedef struct packed {
        rgb_t upper;
        rgb_t middle;
    } line_pair_t;

    localparam int LINE_W = $bits(line_pair_t);

    // Which neighbor rows and columns lie inside the frame.
    typedef struct packed {
        logic row_top;
        logic row_bottom;
        logic col_left;
        logic col_right;
    } tap_mask_t;

    // Item handed from the sequencer to the line store stage.
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic [COL_W-1:0] col;
        rgb_t             pix;
        tap_mask_t        mask;
        logic             eol;
        logic             eof;
    } issue_t;

    // Window indexed [column][row], column 0 leftmost, row 0 topmost.
    typedef rgb_t [2:0][2:0] window_t;

    typedef struct packed {
        logic      valid;
        tap_mask_t mask;
        logic      eol;
        logic      eof;
        window_t   taps;
    } win_stage_t;

    typedef struct packed {
        rgb_t pix;
        logic eol;
        logic eof;
    } result_t;

endpackage

/* design/gbr_stream_if.sv */
// Stream interfaces for input pixels and blurred results.
interface gbr_pix_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output mode, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink (input valid, input mode, input in_red, input in_green,
                  input in_blue, output ready);
endinterface

interface gbr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       end_of_line;
    logic       end_of_frame;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output end_of_line, output end_of_frame, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input end_of_line, input end_of_frame, output ready);
endinterface

/* design/gbr_ram.sv */
// Generic simple dual-port RAM with registered, read-first read data.
module gbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/gbr_ctrl.sv */
// Configuration registers and frame position counters of the blur.
module gbr_ctrl import gbr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_take,
    input  logic                  in_mode,
    input  rgb_t                  in_pix,
    output issue_t                issue,
    output logic                  restart
);

    logic [CFG_WIDTH_W-1:0]  width_reg, width_next;
    logic [CFG_HEIGHT_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]        in_col_reg, in_col_next;
    logic [ROW_W-1:0]        in_row_reg, in_row_next;
    logic [COL_W-1:0]        out_col_reg, out_col_next;
    logic [CFG_HEIGHT_W-1:0] out_row_reg, out_row_next;

    logic [EW_W-1:0]         w_eff;
    logic [CFG_HEIGHT_W-1:0] h_eff;
    logic                    draining;
    logic                    step;
    logic                    col_last;
    logic                    emit;
    logic                    out_eol;
    logic                    out_last_row;

    // Out-of-range geometry is folded into the usable range.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = EW_W'(1);
        end
        else if (EW_W'(width_reg) > EW_W'(MAX_WIDTH))
        begin
            w_eff = EW_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = EW_W'(width_reg);
        end
        h_eff = (height_reg == '0) ? CFG_HEIGHT_W'(1) : height_reg;
    end

    // Position decode for the item at the input.
    always_comb
    begin
        draining = in_row_reg >= ROW_W'(h_eff);
        // A flush item before the frame is complete is dropped.
        step = in_take && !(in_mode && !draining);
        col_last = (EW_W'(in_col_reg) + EW_W'(1)) >= w_eff;
        // Results start once the pixel below and right of the first one arrives.
        emit = !((in_row_reg == '0) || ((in_row_reg == ROW_W'(1)) && (in_col_reg == '0)));
        out_eol = (EW_W'(out_col_reg) + EW_W'(1)) >= w_eff;
        out_last_row = (ROW_W'(out_row_reg) + ROW_W'(1)) >= ROW_W'(h_eff);
    end

    // Item description for the line store stage.
    always_comb
    begin
        issue.valid = step;
        issue.emit = emit;
        issue.col = in_col_reg;
        issue.pix = draining ? '0 : in_pix;
        issue.mask.row_top = (out_row_reg != '0);
        issue.mask.row_bottom = !out_last_row;
        issue.mask.col_left = (out_col_reg != '0);
        issue.mask.col_right = !out_eol;
        issue.eol = out_eol;
        issue.eof = out_eol && out_last_row;
    end

    // Register writes and counter advance.
    always_comb
    begin
        width_next = width_reg;
        height_next = height_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        restart = 1'b0;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:
                begin
                    width_next = cfg_data[CFG_WIDTH_W-1:0];
                    restart = 1'b1;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_next = cfg_data[CFG_HEIGHT_W-1:0];
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
        if (restart)
        begin
            in_col_next = '0;
            in_row_next = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (step)
        begin
            if (col_last)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit)
            begin
                if (issue.eof)
                begin
                    // The frame's last result starts a new frame.
                    in_col_next = '0;
                    in_row_next = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_eol)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + CFG_HEIGHT_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            in_col_reg <= '0;
            in_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            width_reg <= width_next;
            height_reg <= height_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

/* design/gbr_window.sv */
// Line store read-modify-write and the 3x3 sliding window.
module gbr_window import gbr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       restart,
    input  issue_t     issue,
    output win_stage_t stage,
    output logic       s1_busy
);

    logic       s1_valid_reg, s1_valid_next;
    issue_t     s1_reg, s1_next;
    logic       fwd_hit_reg, fwd_hit_next;
    line_pair_t fwd_data_reg, fwd_data_next;
    logic       s2_valid_reg, s2_valid_next;
    tap_mask_t  s2_mask_reg, s2_mask_next;
    logic       s2_eol_reg, s2_eol_next;
    logic       s2_eof_reg, s2_eof_next;
    window_t    taps_reg, taps_next;

    logic [LINE_W-1:0] rd_raw;
    line_pair_t        old_pair;
    line_pair_t        wr_pair;

    // Both line stores share one entry per column.
    gbr_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_reg.col),
        .wdata (wr_pair),
        .raddr (issue.col),
        .rdata (rd_raw)
    );

    // A write to the same column in the read cycle is taken from the bypass.
    always_comb
    begin
        old_pair = fwd_hit_reg ? fwd_data_reg : line_pair_t'(rd_raw);
        wr_pair.upper = old_pair.middle;
        wr_pair.middle = s1_reg.pix;
        s1_busy = s1_valid_reg && s1_reg.emit;
    end

    // Stage registers and window shift.
    always_comb
    begin
        s1_valid_next = issue.valid;
        s1_next = s1_reg;
        fwd_hit_next = fwd_hit_reg;
        fwd_data_next = fwd_data_reg;
        if (issue.valid)
        begin
            s1_next = issue;
            fwd_hit_next = s1_valid_reg && (s1_reg.col == issue.col);
            fwd_data_next = wr_pair;
        end
        s2_valid_next = s1_valid_reg && s1_reg.emit;
        s2_mask_next = s1_reg.mask;
        s2_eol_next = s1_reg.eol;
        s2_eof_next = s1_reg.eof;
        taps_next = taps_reg;
        if (restart)
        begin
            taps_next = '0;
        end
        else if (s1_valid_reg)
        begin
            taps_next[0] = taps_reg[1];
            taps_next[1] = taps_reg[2];
            taps_next[2][0] = old_pair.upper;
            taps_next[2][1] = old_pair.middle;
            taps_next[2][2] = s1_reg.pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            taps_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            taps_reg <= taps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        fwd_hit_reg <= fwd_hit_next;
        fwd_data_reg <= fwd_data_next;
        s2_mask_reg <= s2_mask_next;
        s2_eol_reg <= s2_eol_next;
        s2_eof_reg <= s2_eof_next;
    end

    // Window and masks for the filter.
    always_comb
    begin
        stage.valid = s2_valid_reg;
        stage.mask = s2_mask_reg;
        stage.eol = s2_eol_reg;
        stage.eof = s2_eof_reg;
        stage.taps = taps_reg;
    end

endmodule

/* design/gbr_filter.sv */
// Weighted 1-2-1 kernel sum of the window, divided by 16, per color.
module gbr_filter import gbr_pkg::*; (
    input  win_stage_t stage,
    output logic       result_valid,
    output result_t    result
);

    // Sums the in-frame taps of one color with the separable 1-2-1 weights.
    function automatic logic [7:0] blur(input logic [2:0][2:0][7:0] v,
                                        input tap_mask_t m);
        logic [SUM_W-1:0] sum;
        logic [2:0]       row_ok;
        logic [2:0]       col_ok;
        begin
            row_ok = {m.row_bottom, 1'b1, m.row_top};
            col_ok = {m.col_right, 1'b1, m.col_left};
            sum = '0;
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    if (row_ok[r] && col_ok[c])
                    begin
                        sum = sum + ((SUM_W'(v[c][r]) << ((r == 1) ? 1 : 0))
                                     << ((c == 1) ? 1 : 0));
                    end
                end
            end
            // The sum peaks at 4080, so the quotient never exceeds 255.
            return sum[DIV_SHIFT +: 8];
        end
    endfunction

    logic [2:0][2:0][7:0] red_v;
    logic [2:0][2:0][7:0] green_v;
    logic [2:0][2:0][7:0] blue_v;

    // Split the window into color planes.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                red_v[c][r] = stage.taps[c][r].red;
                green_v[c][r] = stage.taps[c][r].green;
                blue_v[c][r] = stage.taps[c][r].blue;
            end
        end
    end

    always_comb
    begin
        result_valid = stage.valid;
        result.pix.red = blur(red_v, stage.mask);
        result.pix.green = blur(green_v, stage.mask);
        result.pix.blue = blur(blue_v, stage.mask);
        result.eol = stage.eol;
        result.eof = stage.eof;
    end

endmodule

/* design/gbr_out_fifo.sv */
// Small output queue that decouples the pipeline from the receiver.
module gbr_out_fifo import gbr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  result_t               push_data,
    input  logic                  pop,
    output result_t               head,
    output logic                  not_empty,
    output logic [FIFO_CNT_W-1:0] count
);

    result_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    do_pop;

    // Pointer and occupancy update.
    always_comb
    begin
        do_pop = pop && (count_reg != '0);
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count = count_reg;

endmodule

/* design/gaussian_blur_3x3_rgb.sv */
// Top level of the 3x3 Gaussian blur for a raster-order RGB pixel stream.
//
// Pixels enter on pix_in in raster order, one transfer per pixel (mode 0).
// Blurred pixels leave on res_out with end_of_line and end_of_frame flags.
// The result for a pixel is produced by the transfer one line and one pixel
// after it, so after the last pixel the host sends frame_width+1 flush
// transfers (mode 1) to drain the final line. Flush transfers that arrive
// while the frame still expects pixels are taken and dropped.
// Throughput is one pixel per clock while pix_in.ready is high; each transfer
// does one read and one write of a single line store RAM that packs both
// previous lines per column. A result passes s1 and s2 after the transfer
// completing its neighborhood, is queued and can leave on the following
// cycle. When the receiver stalls, the four-entry output queue absorbs the
// results still in flight; pix_in.ready drops only once they would fill it.
// Reset sets the frame to 640x480 and the block accepts at once; the line
// stores are not cleared. Writing either register restarts the frame.
`include "assert_macros.svh"

module gaussian_blur_3x3_rgb import gbr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gbr_pix_if.sink               pix_in,
    gbr_res_if.source             res_out
);

    rgb_t                  in_pix;
    logic                  in_take;
    issue_t                issue;
    logic                  restart;
    win_stage_t            stage;
    logic                  s1_busy;
    logic                  result_valid;
    result_t               result;
    result_t               head;
    logic                  not_empty;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   occupancy;

    // Queue entries plus results still in the pipeline decide the input ready.
    always_comb
    begin
        occupancy = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(s1_busy)
                    + (FIFO_CNT_W + 1)'(stage.valid);
        pix_in.ready = occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
        in_take = pix_in.valid && pix_in.ready;
        in_pix.red = pix_in.in_red;
        in_pix.green = pix_in.in_green;
        in_pix.blue = pix_in.in_blue;
    end

    gbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_take   (in_take),
        .in_mode   (pix_in.mode),
        .in_pix    (in_pix),
        .issue     (issue),
        .restart   (restart)
    );

    gbr_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .issue   (issue),
        .stage   (stage),
        .s1_busy (s1_busy)
    );

    gbr_filter u_filter (
        .stage        (stage),
        .result_valid (result_valid),
        .result       (result)
    );

    gbr_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_valid),
        .push_data (result),
        .pop       (res_out.ready),
        .head      (head),
        .not_empty (not_empty),
        .count     (fifo_count)
    );

    // Result channel.
    always_comb
    begin
        res_out.valid = not_empty;
        res_out.out_red = head.pix.red;
        res_out.out_green = head.pix.green;
        res_out.out_blue = head.pix.blue;
        res_out.end_of_line = head.eol;
        res_out.end_of_frame = head.eof;
    end

    // The queue never holds more than its depth, counting results in flight.
    `ASSERT_ALWAYS(a_queue_bound, occupancy <= (FIFO_CNT_W + 1)'(FIFO_DEPTH),
        "output queue overflow")
    // Input backpressure only happens with a result waiting for the receiver.
    `ASSERT_IMPLIES(a_stall_has_result, !pix_in.ready, res_out.valid,
        "input stalled with no result offered")
    // The frame's last pixel is always also the last pixel of its line.
    `ASSERT_IMPLIES(a_eof_is_eol, res_out.valid && res_out.end_of_frame,
        res_out.end_of_line, "end of frame without end of line")

endmodule
